### rtl/pbce_pkg.sv
package pbce_pkg;

    // Button count the packing logic can produce and the widest supported word
    localparam int PackedButtons = 12;
    localparam int MaxButtons    = 16;
    localparam int DefaultButtons = 12;

    localparam int CfgIndexW = 1;
    localparam int CfgDataW  = 4;
    localparam int ModeW     = 2;
    localparam int DevW      = 4;
    localparam int LinesW    = 6;
    localparam int ByteW     = 8;

    // Configuration register indexes
    localparam logic [CfgIndexW-1:0] REG_PAD_MODE      = 1'd0;
    localparam logic [CfgIndexW-1:0] REG_DEVICE_NUMBER = 1'd1;

    // Pad modes
    localparam logic [ModeW-1:0] MODE_NONE = 2'd0;
    localparam logic [ModeW-1:0] MODE_SIX  = 2'd2;

    localparam logic [ByteW-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [ByteW-1:0] ASCII_LOWER = 8'h61;
    localparam logic [ByteW-1:0] ASCII_UPPER = 8'h41;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIGIT,
        ST_LETTER
    } state_t;

    typedef struct packed {
        logic load;
        logic emit_digit;
        logic emit_letter;
    } cmd_t;

    typedef struct packed {
        logic new_diff_zero;
        logic rest_zero;
        logic out_free;
    } status_t;

endpackage

### rtl/pbce_ctrl.sv
module pbce_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pbce_pkg::status_t status,
    output pbce_pkg::cmd_t    cmd
);
    import pbce_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        in_ready        = 1'b0;
        cmd.load        = 1'b0;
        cmd.emit_digit  = 1'b0;
        cmd.emit_letter = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (!status.new_diff_zero)
                    begin
                        state_next = ST_DIGIT;
                    end
                end
            end
            ST_DIGIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    state_next     = ST_LETTER;
                end
            end
            ST_LETTER:
            begin
                if (status.out_free)
                begin
                    cmd.emit_letter = 1'b1;
                    state_next      = status.rest_zero ? ST_IDLE : ST_DIGIT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/pbce_dp.sv
module pbce_dp
#(
    parameter int BUTTONS = pbce_pkg::DefaultButtons
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wen,
    input  logic [pbce_pkg::CfgIndexW-1:0]    cfg_index,
    input  logic [pbce_pkg::CfgDataW-1:0]     cfg_wdata,
    input  logic [pbce_pkg::LinesW-1:0]       phase0_lines,
    input  logic [pbce_pkg::LinesW-1:0]       phase1_lines,
    input  logic [pbce_pkg::LinesW-1:0]       phase2_lines,
    input  pbce_pkg::cmd_t                    cmd,
    output pbce_pkg::status_t                 status,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [pbce_pkg::ByteW-1:0]        out_byte,
    output logic                              out_last
);
    import pbce_pkg::*;

    localparam int IdxW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

    logic [ModeW-1:0]   pad_mode_reg;
    logic [DevW-1:0]    device_number_reg;
    logic [BUTTONS-1:0] prev_reg;
    logic [BUTTONS-1:0] word_reg;
    logic [BUTTONS-1:0] diff_reg;
    logic               out_valid_reg;
    logic [ByteW-1:0]   out_byte_reg;
    logic               out_last_reg;

    logic [LinesW-1:0]        p2_used;
    logic [PackedButtons-1:0] packed12;
    logic [MaxButtons-1:0]    packed_wide;
    logic [BUTTONS-1:0]       new_word;
    logic [BUTTONS-1:0]       new_diff;
    logic [BUTTONS-1:0]       low_bit;
    logic [BUTTONS-1:0]       rest;
    logic [IdxW-1:0]          low_idx;
    logic                     pressed;
    logic [ByteW-1:0]         letter;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_mode_reg      <= MODE_NONE;
            device_number_reg <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_PAD_MODE:      pad_mode_reg      <= cfg_wdata[ModeW-1:0];
                REG_DEVICE_NUMBER: device_number_reg <= cfg_wdata[DevW-1:0];
                default:           ;
            endcase
        end
    end

    // Button word: right,left,down,up | A | C,B | mode,X,Y,Z | start
    always_comb
    begin
        p2_used  = (pad_mode_reg == MODE_SIX) ? phase2_lines : '0;
        packed12 = {phase1_lines[5], p2_used[3:0], phase0_lines[5:4],
                    phase1_lines[4], phase0_lines[3:0]};
        if (pad_mode_reg == MODE_NONE)
        begin
            packed12 = '0;
        end
        packed_wide = {{(MaxButtons - PackedButtons){1'b0}}, packed12};
        new_word    = packed_wide[BUTTONS-1:0];
        new_diff    = new_word ^ prev_reg;
    end

    // Lowest pending change
    always_comb
    begin
        low_bit = diff_reg & (~diff_reg + BUTTONS'(1));
        rest    = diff_reg & ~low_bit;
        low_idx = '0;
        for (int i = 0; i < BUTTONS; i++)
        begin
            if (low_bit[i])
            begin
                low_idx = low_idx | i[IdxW-1:0];
            end
        end
        pressed = |(word_reg & low_bit);
        letter  = (pressed ? ASCII_LOWER : ASCII_UPPER)
                + {{(ByteW-IdxW){1'b0}}, low_idx};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            word_reg <= new_word;
            diff_reg <= new_diff;
        end
        else if (cmd.emit_letter)
        begin
            diff_reg <= rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
        end
        else if (cmd.load)
        begin
            prev_reg <= new_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_digit || cmd.emit_letter)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_digit)
        begin
            out_byte_reg <= ASCII_ZERO + {{(ByteW-DevW){1'b0}}, device_number_reg};
            out_last_reg <= 1'b0;
        end
        else if (cmd.emit_letter)
        begin
            out_byte_reg <= letter;
            out_last_reg <= (rest == '0);
        end
    end

    assign status.new_diff_zero = (new_diff == '0);
    assign status.rest_zero     = (rest == '0);
    assign status.out_free      = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

### rtl/pad_button_change_event_encoder.sv
// Channel   Fields (tdata / tuser from bit 0 up)                     Direction
// s_axis    tdata: phase0_lines[5:0], phase1_lines[11:6],            in
//           phase2_lines[17:12], zero fill to 24 bits
// m_axis    tdata: out_byte[7:0]; tlast: last                        out
// cfg       cfg_wen, cfg_index, cfg_wdata (pad_mode, device_number)  in
//
// A poll is taken in the idle state; each changed button then gives two output
// bytes, the device-number digit and then the button letter, so a poll with k
// changes gives 2k bytes (at most 2*BUTTONS). A poll with no changes gives none.
// The controller's digit and letter states sequence these bytes.
// Reset clears the previous button word (all released) and both registers.
// A stall on m_axis holds the controller; s_tready is high only between polls.
module pad_button_change_event_encoder
#(
    parameter int BUTTONS = pbce_pkg::DefaultButtons
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wen,
    input  logic [pbce_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [pbce_pkg::CfgDataW-1:0]  cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,  // phase0, phase1, phase2, zero fill
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,  // out_byte
    output logic                           m_tlast
);
    import pbce_pkg::*;

    cmd_t    cmd;
    status_t status;

    pbce_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pbce_dp #(.BUTTONS(BUTTONS)) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .phase0_lines (s_tdata[5:0]),
        .phase1_lines (s_tdata[11:6]),
        .phase2_lines (s_tdata[17:12]),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_byte     (m_tdata),
        .out_last     (m_tlast)
    );

    // A pending non-final byte means the poll is still being worked on
    a_busy_while_partial: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("new request possible while poll bytes remain");

    // The next byte of a poll is ready right after the previous one is taken
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside a poll's byte sequence");

    // Hold a stalled byte until it is taken
    a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output byte changed while stalled");

endmodule
